// File: hdl/complex_matrix_unitarity_check_top_defines.svh
// Assertion macros shared by the checker.
`ifndef COMPLEX_MATRIX_UNITARITY_CHECK_TOP_DEFINES_SVH
`define COMPLEX_MATRIX_UNITARITY_CHECK_TOP_DEFINES_SVH
`define CMU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CMU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: hdl/cmu_pkg.sv
package cmu_pkg;
   localparam int CFG_IDX_W = 1;
   localparam logic [CFG_IDX_W-1:0] REG_MATRIX_DIM = 1'd0;
   localparam logic [CFG_IDX_W-1:0] REG_EPS_THRESHOLD = 1'd1;
   localparam int CFG_DATA_W = 40;
   localparam int DIM_W = 5;
   localparam int IDX_W = 4;
   localparam int FRAC_BITS = 16;
   localparam int SQ_W = 40;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_START,
      ST_MAC,
      ST_DRAIN,
      ST_CHECK,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic clear_acc;
      logic issue;
      logic entry_done;
      logic check;
      logic is_diag;
   } cmd_type;

   typedef struct packed {
      logic fail;
   } status_type;
endpackage

// File: hdl/cmu_datapath.sv
module cmu_datapath #(
   parameter int MAX_DIM = 16,
   parameter int ELEM_WIDTH = 18
) (
   input  logic clock,
   input  logic reset,
   input  logic wr_en,
   input  logic [2*$clog2((MAX_DIM > 1) ? MAX_DIM : 2)-1:0] wr_addr,
   input  logic signed [ELEM_WIDTH-1:0] wr_re,
   input  logic signed [ELEM_WIDTH-1:0] wr_im,
   input  logic [2*$clog2((MAX_DIM > 1) ? MAX_DIM : 2)-1:0] rd_addr_a,
   input  logic [2*$clog2((MAX_DIM > 1) ? MAX_DIM : 2)-1:0] rd_addr_b,
   input  logic [cmu_pkg::SQ_W-1:0] eps,
   input  cmu_pkg::cmd_type cmd,
   output cmu_pkg::status_type status
);
   import cmu_pkg::*;
   localparam int XW = $clog2((MAX_DIM > 1) ? MAX_DIM : 2);
   localparam int DEPTH = 1 << (2 * XW);
   localparam int PW = 2 * ELEM_WIDTH + 1;
   localparam int AW = 64;
   localparam int HW = 20;
   localparam int LW = 16;
   localparam int SUMW = 32 + SQ_W + 2;

   logic signed [ELEM_WIDTH-1:0] re_mem [DEPTH];
   logic signed [ELEM_WIDTH-1:0] im_mem [DEPTH];
   logic signed [ELEM_WIDTH-1:0] ar_ff, ai_ff, br_ff, bi_ff;
   logic v1_ff, v2_ff;
   logic signed [PW-1:0] p_re_ff, p_im_ff;
   logic signed [AW-1:0] acc_re_ff, acc_im_ff;
   logic [AW-1:0] dre_in, mre_in, mim_in;
   logic [AW-1:0] mre_ff, mim_ff;
   logic sat_in;
   logic [HW-1:0] hre_in, him_in;
   logic [LW-1:0] lre_in, lim_in;
   logic [2*HW-1:0] hre_sq_in, him_sq_in;
   logic [HW+LW-1:0] hl_re_in, hl_im_in;
   logic [2*LW-1:0] lre_sq_in, lim_sq_in;
   logic [2*HW:0] hh_ff;
   logic [HW+LW:0] hl_ff;
   logic [2*LW:0] ll_ff;
   logic sat_ff;
   logic [SUMW-1:0] tot_in;
   logic [SQ_W-1:0] sq_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         re_mem[wr_addr] <= wr_re;
         im_mem[wr_addr] <= wr_im;
      end
      ar_ff <= re_mem[rd_addr_a];
      ai_ff <= im_mem[rd_addr_a];
      br_ff <= re_mem[rd_addr_b];
      bi_ff <= im_mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_re_ff <= PW'(ar_ff * br_ff) + PW'(ai_ff * bi_ff);
      p_im_ff <= PW'(ai_ff * br_ff) - PW'(ar_ff * bi_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_acc) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (v2_ff) begin
         acc_re_ff <= acc_re_ff + AW'(p_re_ff);
         acc_im_ff <= acc_im_ff + AW'(p_im_ff);
      end
   end

   always_comb begin
      dre_in = acc_re_ff - (cmd.is_diag ? (AW'(1) << (2 * FRAC_BITS)) : AW'(0));
      mre_in = dre_in[AW-1] ? (AW'(0) - dre_in) : dre_in;
      mim_in = acc_im_ff[AW-1] ? (AW'(0) - acc_im_ff) : acc_im_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.entry_done) begin
         mre_ff <= mre_in;
         mim_ff <= mim_in;
      end
   end

   // Bits 35:0 of each magnitude are split into a 20-bit high and a 16-bit low part; higher bits saturate.
   always_comb begin
      sat_in = (mre_ff[AW-1:36] != '0) || (mim_ff[AW-1:36] != '0);
      hre_in = mre_ff[35:16];
      him_in = mim_ff[35:16];
      lre_in = mre_ff[15:0];
      lim_in = mim_ff[15:0];
      hre_sq_in = hre_in * hre_in;
      him_sq_in = him_in * him_in;
      hl_re_in = hre_in * lre_in;
      hl_im_in = him_in * lim_in;
      lre_sq_in = lre_in * lre_in;
      lim_sq_in = lim_in * lim_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         sat_ff <= sat_in;
         hh_ff <= {1'b0, hre_sq_in} + {1'b0, him_sq_in};
         hl_ff <= {1'b0, hl_re_in} + {1'b0, hl_im_in};
         ll_ff <= {1'b0, lre_sq_in} + {1'b0, lim_sq_in};
      end
   end

   always_comb begin
      tot_in = SUMW'({hh_ff, 32'd0}) + (SUMW'(hl_ff) << 17) + SUMW'(ll_ff);
   end

   always_ff @(posedge clock) begin
      sq_ff <= (sat_ff || tot_in[SUMW-1:32+SQ_W] != '0) ? '1 : tot_in[32+SQ_W-1:32];
   end

   assign status.fail = sq_ff > eps;
endmodule

// File: hdl/cmu_ctrl.sv
module cmu_ctrl #(
   parameter int MAX_DIM = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [cmu_pkg::DIM_W-1:0] dim,
   input  logic rsp_ready,
   input  cmu_pkg::status_type status,
   output cmu_pkg::cmd_type cmd,
   output logic [2*$clog2((MAX_DIM > 1) ? MAX_DIM : 2)-1:0] rd_addr_a,
   output logic [2*$clog2((MAX_DIM > 1) ? MAX_DIM : 2)-1:0] rd_addr_b,
   output logic busy,
   output logic rsp_valid,
   output logic rsp_is_unitary
);
   import cmu_pkg::*;
   localparam int CW = $clog2(MAX_DIM + 1);
   localparam int XW = $clog2((MAX_DIM > 1) ? MAX_DIM : 2);

   state_type state_ff, state_in;
   logic [CW-1:0] dim_ff, r_ff, c_ff, i_ff;
   logic [2:0] wait_ff;
   logic result_ff;
   logic [CW-1:0] dim_in;

   always_comb begin
      dim_in = (32'(dim) > MAX_DIM) ? CW'(MAX_DIM) : CW'(dim);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: if (start) state_in = ST_START;
         ST_START: state_in = (dim_ff == '0) ? ST_RESULT : ST_MAC;
         ST_MAC: if (i_ff == dim_ff - CW'(1)) state_in = ST_DRAIN;
         ST_DRAIN: if (wait_ff == 3'd3) state_in = ST_CHECK;
         ST_CHECK: begin
            if (wait_ff == 3'd2) begin
               if (status.fail) state_in = ST_RESULT;
               else if (r_ff == dim_ff - CW'(1) && c_ff == dim_ff - CW'(1))
                  state_in = ST_RESULT;
               else state_in = ST_MAC;
            end
         end
         ST_RESULT: if (rsp_ready) state_in = ST_LOAD;
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         dim_ff <= '0;
         r_ff <= '0;
         c_ff <= '0;
         i_ff <= '0;
         wait_ff <= '0;
         result_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_LOAD: begin
               dim_ff <= dim_in;
               r_ff <= '0;
               c_ff <= '0;
               i_ff <= '0;
               result_ff <= 1'b1;
            end
            ST_MAC: begin
               i_ff <= i_ff + CW'(1);
               wait_ff <= '0;
            end
            ST_DRAIN: wait_ff <= (wait_ff == 3'd3) ? 3'd0 : wait_ff + 3'd1;
            ST_CHECK: begin
               wait_ff <= wait_ff + 3'd1;
               if (wait_ff == 3'd2) begin
                  i_ff <= '0;
                  if (status.fail) result_ff <= 1'b0;
                  if (c_ff == dim_ff - CW'(1)) begin
                     c_ff <= '0;
                     r_ff <= r_ff + CW'(1);
                  end else begin
                     c_ff <= c_ff + CW'(1);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      cmd = '0;
      cmd.is_diag = (r_ff == c_ff);
      case (state_ff)
         ST_START: cmd.clear_acc = 1'b1;
         ST_MAC: cmd.issue = 1'b1;
         ST_DRAIN: cmd.entry_done = (wait_ff == 3'd3);
         ST_CHECK: begin
            cmd.check = (wait_ff == 3'd0);
            cmd.clear_acc = (wait_ff == 3'd2);
         end
         default: ;
      endcase
   end

   assign rd_addr_a = {XW'(r_ff), XW'(i_ff)};
   assign rd_addr_b = {XW'(c_ff), XW'(i_ff)};
   assign busy = (state_ff != ST_LOAD);
   assign rsp_valid = (state_ff == ST_RESULT);
   assign rsp_is_unitary = result_ff;
endmodule

// File: hdl/complex_matrix_unitarity_check_top.sv
// Channel   Ports             Purpose
// req       req_valid/ready   one matrix element per beat
// rsp       rsp_valid/ready   one verdict after a beat marked last
// csr       csr_write_en      matrix_dim and eps_threshold writes
// Loading takes a new beat every clock while the checker is not busy. After the
// last beat one complex multiply-accumulate unit walks dim*dim entries of dim
// steps each, then drains and compares each entry against the threshold.
// The first failing entry ends the walk. Reset is synchronous and needs no
// clearing pass. A held response stalls further loading.
module complex_matrix_unitarity_check_top #(
   parameter int MAX_DIM = 16,
   parameter int ELEM_WIDTH = 18
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [3:0] req_row_index,
   input  logic [3:0] req_col_index,
   input  logic signed [ELEM_WIDTH-1:0] req_elem_re,
   input  logic signed [ELEM_WIDTH-1:0] req_elem_im,
   input  logic req_last_elem,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_is_unitary,
   input  logic csr_write_en,
   input  logic [cmu_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [cmu_pkg::CFG_DATA_W-1:0] csr_wdata
);
   import cmu_pkg::*;
   localparam int XW = $clog2((MAX_DIM > 1) ? MAX_DIM : 2);
   localparam int AW = 2 * XW;

   logic [DIM_W-1:0] dim_ff;
   logic [SQ_W-1:0] eps_ff;
   logic busy, accept, in_range;
   cmd_type cmd;
   status_type status;
   logic [AW-1:0] rd_a, rd_b, wr_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_W'(4);
         eps_ff <= SQ_W'(4295);
      end else if (csr_write_en) begin
         case (csr_index)
            REG_MATRIX_DIM: dim_ff <= csr_wdata[DIM_W-1:0];
            REG_EPS_THRESHOLD: eps_ff <= csr_wdata[SQ_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = !busy;
   assign accept = req_valid && req_ready;
   assign in_range = (32'(req_row_index) < MAX_DIM) && (32'(req_col_index) < MAX_DIM);
   assign wr_addr = {XW'(req_row_index), XW'(req_col_index)};

   cmu_datapath #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_dp (
      .clock(clock), .reset(reset),
      .wr_en(accept && in_range), .wr_addr(wr_addr),
      .wr_re(req_elem_re), .wr_im(req_elem_im),
      .rd_addr_a(rd_a), .rd_addr_b(rd_b), .eps(eps_ff),
      .cmd(cmd), .status(status)
   );

   cmu_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
      .clock(clock), .reset(reset),
      .start(accept && req_last_elem), .dim(dim_ff),
      .rsp_ready(rsp_ready), .status(status), .cmd(cmd),
      .rd_addr_a(rd_a), .rd_addr_b(rd_b), .busy(busy),
      .rsp_valid(rsp_valid), .rsp_is_unitary(rsp_is_unitary)
   );
endmodule

// File: hdl/cmu_checker.sv
`include "complex_matrix_unitarity_check_top_defines.svh"
module cmu_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_last_elem,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_is_unitary
);
   `CMU_ASSERT_IMPL(a_no_load_during_rsp, clock, reset, rsp_valid, !req_ready)
   `CMU_ASSERT_NEXT(a_last_blocks, clock, reset, req_valid && req_ready && req_last_elem, !req_ready)
   `CMU_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_is_unitary))
endmodule

bind complex_matrix_unitarity_check_top cmu_checker u_cmu_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_last_elem(req_last_elem), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_is_unitary(rsp_is_unitary)
);
